### src/mmd_pkg.sv
// Package for the MIDI message decoder: event and status codes,
// the command type passed from the parser to the event expander.
// No dependencies.
package mmd_pkg;

	localparam int CMD_DEPTH = 4;

	localparam logic [4:0] EV_NOTE_ON       = 5'd0;
	localparam logic [4:0] EV_NOTE_OFF      = 5'd1;
	localparam logic [4:0] EV_POLY_PRESSURE = 5'd2;
	localparam logic [4:0] EV_CONTROL       = 5'd3;
	localparam logic [4:0] EV_PROGRAM       = 5'd4;
	localparam logic [4:0] EV_CHAN_PRESSURE = 5'd5;
	localparam logic [4:0] EV_BEND          = 5'd6;
	localparam logic [4:0] EV_LOCAL         = 5'd7;
	localparam logic [4:0] EV_ALL_OFF       = 5'd8;
	localparam logic [4:0] EV_OMNI          = 5'd9;
	localparam logic [4:0] EV_MONO          = 5'd10;
	localparam logic [4:0] EV_POLY          = 5'd11;
	localparam logic [4:0] EV_SYSEX_BYTE    = 5'd12;
	localparam logic [4:0] EV_SYSEX_END     = 5'd13;
	localparam logic [4:0] EV_SONG_POS      = 5'd14;
	localparam logic [4:0] EV_SONG_SEL      = 5'd15;
	localparam logic [4:0] EV_SYSTEM        = 5'd16;

	localparam logic [6:0] SYS_TUNE     = 7'd0;
	localparam logic [6:0] SYS_CLOCK    = 7'd1;
	localparam logic [6:0] SYS_START    = 7'd2;
	localparam logic [6:0] SYS_CONTINUE = 7'd3;
	localparam logic [6:0] SYS_STOP     = 7'd4;
	localparam logic [6:0] SYS_SENSE    = 7'd5;
	localparam logic [6:0] SYS_RESET    = 7'd6;

	localparam logic [3:0] MSG_NOTE_OFF  = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON   = 4'h9;
	localparam logic [3:0] MSG_POLY      = 4'hA;
	localparam logic [3:0] MSG_CONTROL   = 4'hB;
	localparam logic [3:0] MSG_PROGRAM   = 4'hC;
	localparam logic [3:0] MSG_CHAN_PRES = 4'hD;
	localparam logic [3:0] MSG_BEND      = 4'hE;
	localparam logic [3:0] MSG_SYSTEM    = 4'hF;

	localparam logic [7:0] ST_SYSEX      = 8'hF0;
	localparam logic [7:0] ST_SONG_POS   = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
	localparam logic [7:0] ST_TUNE       = 8'hF6;
	localparam logic [7:0] ST_SYSEX_END  = 8'hF7;
	localparam logic [7:0] ST_RT_CLOCK   = 8'hF8;
	localparam logic [7:0] ST_RT_START   = 8'hFA;
	localparam logic [7:0] ST_RT_CONT    = 8'hFB;
	localparam logic [7:0] ST_RT_STOP    = 8'hFC;
	localparam logic [7:0] ST_RT_SENSE   = 8'hFE;
	localparam logic [7:0] ST_RT_RESET   = 8'hFF;

	localparam logic [6:0] CC_LOCAL      = 7'd122;
	localparam logic [6:0] CC_ALL_OFF    = 7'd123;
	localparam logic [6:0] CC_OMNI_OFF   = 7'd124;
	localparam logic [6:0] CC_OMNI_ON    = 7'd125;
	localparam logic [6:0] CC_MONO       = 7'd126;
	localparam logic [6:0] CC_POLY       = 7'd127;

	localparam logic [13:0] BEND_CENTER  = 14'h2000;

	typedef struct packed {
		logic        expand;
		logic [4:0]  kind;
		logic [3:0]  channel;
		logic [6:0]  number;
		logic [6:0]  amount;
		logic [13:0] bend;
		logic [13:0] position;
	} mmd_cmd_t;

endpackage

### src/mmd_front.sv
// Byte parser: keeps running status, the first data byte and the sysex flag,
// and turns each byte into at most one command. Depends on mmd_pkg.
module mmd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        midi_byte,
	output logic              cmd_push,
	output mmd_pkg::mmd_cmd_t cmd
);
	import mmd_pkg::*;

	logic [7:0] status_q;
	logic [6:0] first_q;
	logic       pending_q;
	logic       sysex_q;
	logic [7:0] status_d;
	logic [6:0] first_d;
	logic       pending_d;
	logic       sysex_d;
	logic [6:0] d;
	logic [3:0] msg;
	logic [13:0] word;

	assign d    = midi_byte[6:0];
	assign msg  = status_q[7:4];
	assign word = {d, first_q};

	always_comb begin
		status_d  = status_q;
		first_d   = first_q;
		pending_d = pending_q;
		sysex_d   = sysex_q;
		cmd_push  = 1'b0;
		cmd       = '0;
		if (midi_byte >= ST_RT_CLOCK) begin
			cmd.kind = EV_SYSTEM;
			cmd_push = 1'b1;
			case (midi_byte)
				ST_RT_CLOCK: cmd.number = SYS_CLOCK;
				ST_RT_START: cmd.number = SYS_START;
				ST_RT_CONT:  cmd.number = SYS_CONTINUE;
				ST_RT_STOP:  cmd.number = SYS_STOP;
				ST_RT_SENSE: cmd.number = SYS_SENSE;
				ST_RT_RESET: cmd.number = SYS_RESET;
				default:     cmd_push   = 1'b0;
			endcase
		end else if (midi_byte[7]) begin
			status_d  = midi_byte;
			pending_d = 1'b0;
			sysex_d   = (midi_byte == ST_SYSEX);
			if (midi_byte == ST_SYSEX_END && sysex_q) begin
				cmd.kind = EV_SYSEX_END;
				cmd_push = 1'b1;
			end else if (midi_byte == ST_TUNE) begin
				cmd.kind   = EV_SYSTEM;
				cmd.number = SYS_TUNE;
				cmd_push   = 1'b1;
			end
		end else if (sysex_q) begin
			cmd.kind   = EV_SYSEX_BYTE;
			cmd.number = d;
			cmd_push   = 1'b1;
		end else if (status_q[7]) begin
			if (msg == MSG_PROGRAM) begin
				cmd.kind    = EV_PROGRAM;
				cmd.channel = status_q[3:0];
				cmd.number  = d;
				cmd_push    = 1'b1;
			end else if (msg == MSG_CHAN_PRES) begin
				cmd.kind    = EV_CHAN_PRESSURE;
				cmd.channel = status_q[3:0];
				cmd.amount  = d;
				cmd_push    = 1'b1;
			end else if (status_q == ST_SONG_SEL) begin
				cmd.kind   = EV_SONG_SEL;
				cmd.number = d;
				cmd_push   = 1'b1;
			end else if (msg == MSG_SYSTEM && status_q != ST_SONG_POS) begin
				cmd_push = 1'b0;
			end else if (!pending_q) begin
				first_d   = d;
				pending_d = 1'b1;
			end else begin
				pending_d   = 1'b0;
				cmd_push    = 1'b1;
				cmd.channel = status_q[3:0];
				cmd.number  = first_q;
				cmd.amount  = d;
				case (msg)
					MSG_NOTE_OFF: cmd.kind = EV_NOTE_OFF;
					MSG_NOTE_ON:  cmd.kind = (d != 7'd0) ? EV_NOTE_ON : EV_NOTE_OFF;
					MSG_POLY:     cmd.kind = EV_POLY_PRESSURE;
					MSG_CONTROL: begin
						case (first_q)
							CC_LOCAL: begin
								cmd.kind   = EV_LOCAL;
								cmd.amount = {6'd0, d != 7'd0};
							end
							CC_ALL_OFF: begin
								cmd.kind   = EV_ALL_OFF;
								cmd.amount = '0;
							end
							CC_OMNI_OFF, CC_OMNI_ON, CC_MONO, CC_POLY: begin
								cmd.kind   = EV_ALL_OFF;
								cmd.expand = 1'b1;
							end
							default: cmd.kind = EV_CONTROL;
						endcase
					end
					MSG_BEND: begin
						cmd.kind   = EV_BEND;
						cmd.number = '0;
						cmd.amount = '0;
						cmd.bend   = word - BEND_CENTER;
					end
					default: begin
						cmd.kind     = EV_SONG_POS;
						cmd.channel  = '0;
						cmd.number   = '0;
						cmd.amount   = '0;
						cmd.position = word;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= '0;
			first_q   <= '0;
			pending_q <= 1'b0;
			sysex_q   <= 1'b0;
		end else if (accept) begin
			status_q  <= status_d;
			first_q   <= first_d;
			pending_q <= pending_d;
			sysex_q   <= sysex_d;
		end
	end

endmodule

### src/mmd_cmd_fifo.sv
// Short command queue between the parser and the event expander.
// Depends on mmd_pkg.
module mmd_cmd_fifo #(
	parameter int Depth = mmd_pkg::CMD_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  mmd_pkg::mmd_cmd_t wr_data,
	input  logic              rd_en,
	output mmd_pkg::mmd_cmd_t rd_data,
	output logic              full,
	output logic              not_empty
);
	import mmd_pkg::*;

	localparam int PTR_W = $clog2(Depth);
	localparam int CNT_W = $clog2(Depth + 1);

	mmd_cmd_t         mem_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full      = (count_q == CNT_W'(Depth));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(Depth))
		else $error("Command queue count exceeds its depth.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Command queue count missed a write.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q == rd_ptr_q) |-> (count_q == '0 || full))
		else $error("Command queue pointers disagree with the count.");

endmodule

### src/mmd_back.sv
// Event expander: turns each command into one to three events and holds
// the oldest event in an output register. Depends on mmd_pkg.
module mmd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  mmd_pkg::mmd_cmd_t cmd,
	output logic              cmd_pop,
	input  logic              pop,
	output logic              empty,
	output logic [4:0]        event_kind,
	output logic [3:0]        channel,
	output logic [6:0]        number,
	output logic [6:0]        amount,
	output logic [13:0]       bend,
	output logic [13:0]       position,
	output logic              last
);
	import mmd_pkg::*;

	logic [1:0]  step_q;
	logic        out_valid_q;
	logic [4:0]  kind_q;
	logic [3:0]  channel_q;
	logic [6:0]  number_q;
	logic [6:0]  amount_q;
	logic [13:0] bend_q;
	logic [13:0] position_q;
	logic        last_q;
	logic        load;
	logic [4:0]  ev_kind;
	logic [6:0]  ev_amount;
	logic        ev_last;
	logic [3:0]  low4;

	assign load    = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop = load && ev_last;
	assign low4    = cmd.amount[3:0];

	always_comb begin
		ev_kind   = cmd.kind;
		ev_amount = cmd.amount;
		ev_last   = 1'b1;
		if (cmd.expand) begin
			case (step_q)
				2'd0: begin
					ev_kind   = EV_ALL_OFF;
					ev_amount = '0;
					ev_last   = 1'b0;
				end
				2'd1: begin
					case (cmd.number)
						CC_OMNI_OFF: begin
							ev_kind   = EV_OMNI;
							ev_amount = '0;
						end
						CC_OMNI_ON: begin
							ev_kind   = EV_OMNI;
							ev_amount = 7'd1;
						end
						CC_MONO: begin
							ev_kind   = EV_OMNI;
							ev_amount = {6'd0, low4 == 4'd0};
							ev_last   = 1'b0;
						end
						default: begin
							ev_kind   = EV_POLY;
							ev_amount = '0;
						end
					endcase
				end
				default: begin
					ev_kind   = EV_MONO;
					ev_amount = {3'd0, low4};
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q     <= ev_kind;
			channel_q  <= cmd.channel;
			number_q   <= cmd.number;
			amount_q   <= ev_amount;
			bend_q     <= cmd.bend;
			position_q <= cmd.position;
			last_q     <= ev_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= ev_last ? 2'd0 : step_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty      = !out_valid_q;
	assign event_kind = kind_q;
	assign channel    = channel_q;
	assign number     = number_q;
	assign amount     = amount_q;
	assign bend       = bend_q;
	assign position   = position_q;
	assign last       = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != 2'd0) |-> (cmd_valid && cmd.expand))
		else $error("Expansion step is set without a mode command at the head.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == 2'd2) |-> (cmd.number == CC_MONO))
		else $error("Third expansion step on a controller other than mono.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && out_valid_q && !load) |=> !out_valid_q)
		else $error("Output register kept a beat that was taken.");

endmodule

### src/midi_message_decoder_unit.sv
// Top level of the MIDI message decoder: parser, command queue and
// event expander. Depends on mmd_pkg, mmd_front, mmd_cmd_fifo, mmd_back.
//
//   Channel   Direction  Handshake        Beat
//   input     in         push / full      midi_byte
//   result    out        empty / pop      event_kind, channel, number, amount,
//                                         bend, position, last
//
// A byte is taken in any cycle in which the command queue has room; its command is written
// into the queue and from there loaded into the result register once that register is empty
// or being popped. The expander emits one event per cycle while the result register is free
// or popped: mode controllers 124, 125 and 127 expand into two events and 126 into three.
// full rises when CmdDepth commands wait. Reset empties the queue and the result register
// and clears running status.
module midi_message_decoder_unit #(
	parameter int CmdDepth = mmd_pkg::CMD_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         midi_byte,
	output logic               empty,
	input  logic               pop,
	output logic [4:0]         event_kind,
	output logic [3:0]         channel,
	output logic [6:0]         number,
	output logic [6:0]         amount,
	output logic signed [13:0] bend,
	output logic [13:0]        position,
	output logic               last
);
	import mmd_pkg::*;

	logic        accept;
	logic        cmd_push;
	mmd_cmd_t    front_cmd;
	mmd_cmd_t    head_cmd;
	logic        head_valid;
	logic        head_pop;
	logic [13:0] bend_raw;

	assign accept = push && !full;
	assign bend   = $signed(bend_raw);

	mmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.midi_byte (midi_byte),
		.cmd_push  (cmd_push),
		.cmd       (front_cmd)
	);

	mmd_cmd_fifo #(
		.Depth (CmdDepth)
	) u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept && cmd_push),
		.wr_data   (front_cmd),
		.rd_en     (head_pop),
		.rd_data   (head_cmd),
		.full      (full),
		.not_empty (head_valid)
	);

	mmd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (head_valid),
		.cmd        (head_cmd),
		.cmd_pop    (head_pop),
		.pop        (pop),
		.empty      (empty),
		.event_kind (event_kind),
		.channel    (channel),
		.number     (number),
		.amount     (amount),
		.bend       (bend_raw),
		.position   (position),
		.last       (last)
	);

endmodule
